[hw/rtl/rank_limited_mf_sgd_update_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rank limited factorization update engine
// Shared property forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RANK_LIMITED_MF_SGD_UPDATE_ASSERT_SVH
`define RANK_LIMITED_MF_SGD_UPDATE_ASSERT_SVH

// same-cycle implication
`define RLMF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RLMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rlmf_pkg.sv]
// ----------------------------------------------------------------------------
// rlmf_pkg
// Types, widths, codes and saturation helper of the factorization engine.
// ----------------------------------------------------------------------------
package rlmf_pkg;

  localparam int VALUE_W    = 24;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 10;
  localparam int POS_W      = 5;
  localparam int RANK_OUT_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int OP_W       = 3;

  localparam logic [COEF_W-1:0] COEF_RESET = 16'd655;

  localparam logic signed [VALUE_W-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_W-1:0] Q_MIN = 24'sh800000;

  typedef enum logic [OP_W-1:0] {
    OP_WR_USER   = 3'd0,
    OP_WR_ITEM   = 3'd1,
    OP_SET_URANK = 3'd2,
    OP_SET_IRANK = 3'd3,
    OP_ESTIMATE  = 3'd4,
    OP_TRAIN     = 3'd5,
    OP_RD_USER   = 3'd6,
    OP_RD_ITEM   = 3'd7
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE = 2'd0,
    CFG_USER_REG   = 2'd1,
    CFG_ITEM_REG   = 2'd2
  } cfg_idx_t;

  function automatic logic signed [VALUE_W-1:0] sat_q(input logic signed [63:0] x);
    logic signed [VALUE_W-1:0] r;
    if (x > 64'(Q_MAX)) begin
      r = Q_MAX;
    end else if (x < 64'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = VALUE_W'(x);
    end
    return r;
  endfunction

endpackage

[hw/rtl/rlmf_ram.sv]
// ----------------------------------------------------------------------------
// rlmf_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rlmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rank_limited_mf_sgd_update.sv]
// ----------------------------------------------------------------------------
// rank_limited_mf_sgd_update
// Latent factor tables in RAM, per-row ranks, dot product estimate and
// two-table gradient step, with factor loads, reads and rank sets.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; the factor RAM ports issue one factor per
//   cycle for the dot pass and again for the fused user/item update pass.
// Reset: a rank clearing pass over max(NUM_USERS, NUM_ITEMS) rows runs first;
//   no item is accepted until it ends. Factor tables are not cleared.
module rank_limited_mf_sgd_update #(
  parameter int NUM_USERS = 1024,
  parameter int NUM_ITEMS = 1024,
  parameter int FAC_DIM   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rlmf_pkg::IN_DATA_W-1:0]    s_tdata,   // user, item, index, value, pad
  input  logic [rlmf_pkg::OP_W-1:0]         s_tuser,   // op
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rlmf_pkg::OUT_DATA_W-1:0]   m_tdata,   // result_value, rank_used, pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlmf_pkg::COEF_W-1:0]       cfg_data
);

  `include "rank_limited_mf_sgd_update_assert.svh"

  localparam int UAW   = $clog2(NUM_USERS * FAC_DIM);
  localparam int IAW   = $clog2(NUM_ITEMS * FAC_DIM);
  localparam int URW   = $clog2(NUM_USERS);
  localparam int IRW   = $clog2(NUM_ITEMS);
  localparam int RKW   = $clog2(FAC_DIM + 1);
  localparam int CLR_N = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS;
  localparam int CLW   = $clog2(CLR_N);
  localparam int ACC_W = 48 + RKW;
  localparam int VW    = rlmf_pkg::VALUE_W;
  localparam int CW    = rlmf_pkg::COEF_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FRD   = 9'b000000100,
    S_RANK  = 9'b000001000,
    S_DOT   = 9'b000010000,
    S_EST   = 9'b000100000,
    S_ERR   = 9'b001000000,
    S_UPD   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t st;

  logic [CW-1:0] lr, ureg, ireg;

  // input unpack
  logic [rlmf_pkg::ROW_W-1:0] in_user, in_item;
  logic [rlmf_pkg::POS_W-1:0] in_pos;
  logic signed [VW-1:0]       in_val;
  rlmf_pkg::op_t              in_op;
  logic                       accept, u_ok, i_ok, p_ok;
  logic [RKW-1:0]             rclamp;
  logic [UAW-1:0]             u_row_base;
  logic [IAW-1:0]             i_row_base;

  assign in_user = s_tdata[9:0];
  assign in_item = s_tdata[19:10];
  assign in_pos  = s_tdata[24:20];
  assign in_val  = $signed(s_tdata[48:25]);
  assign in_op   = rlmf_pkg::op_t'(s_tuser);
  assign s_tready = (st == S_IDLE);
  assign accept  = s_tvalid && s_tready;
  assign u_ok    = int'(in_user) < NUM_USERS;
  assign i_ok    = int'(in_item) < NUM_ITEMS;
  assign p_ok    = int'(in_pos) < FAC_DIM;
  assign u_row_base = UAW'(in_user) * UAW'(FAC_DIM);
  assign i_row_base = IAW'(in_item) * IAW'(FAC_DIM);

  always_comb begin
    if (int'(in_val) < 1) begin
      rclamp = RKW'(1);
    end else if (int'(in_val) > FAC_DIM) begin
      rclamp = RKW'(FAC_DIM);
    end else begin
      rclamp = RKW'(in_val);
    end
  end

  // item registers
  rlmf_pkg::op_t        op_q;
  logic signed [VW-1:0] val_q;
  logic [UAW-1:0]       ubase;
  logic [IAW-1:0]       ibase;
  logic [RKW-1:0]       rk, cnt;
  logic [CLW-1:0]       clr;
  logic signed [ACC_W-1:0] acc, acc_r, acc_s;
  logic signed [VW-1:0] est, err, res_val;
  logic signed [VW:0]   diff;
  logic [RKW-1:0]       res_rank;

  // issue pipeline
  logic           issue, rd_v;
  logic [RKW-1:0] rd_k;
  logic           pv;
  logic signed [47:0] pp;

  // memories
  logic           u_we, i_we, ur_we, ir_we;
  logic [UAW-1:0] u_waddr, u_raddr;
  logic [IAW-1:0] i_waddr, i_raddr;
  logic [VW-1:0]  u_wdata, i_wdata, u_rdata, i_rdata;
  logic [URW-1:0] ur_waddr;
  logic [IRW-1:0] ir_waddr;
  logic [RKW-1:0] ur_wdata, ir_wdata, ur_rdata, ir_rdata;

  // update lanes: lane 0 user row, lane 1 item row
  logic [1:0]            ln_v, a_v, b_v, c_v, d_v;
  logic signed [VW-1:0]  ln_x [2];
  logic signed [VW-1:0]  ln_y [2];
  logic [RKW-1:0]        ln_k [2];
  logic [CW-1:0]         ln_reg [2];
  logic signed [47:0]    a_p1 [2];
  logic signed [40:0]    a_p2 [2];
  logic signed [VW-1:0]  a_y [2], b_y [2], c_y [2], d_new [2];
  logic [RKW-1:0]        a_k [2], b_k [2], c_k [2], d_k [2];
  logic signed [37:0]    b_g [2];
  logic signed [38:0]    c_h [2];
  logic [31:0]           c_l [2];
  logic signed [53:0]    grad [2], grad_r [2];
  logic signed [55:0]    prod [2], prod_r [2];
  logic signed [41:0]    dsum [2];
  logic signed [VW-1:0]  a_x, b_x, c_x, d_x;

  assign issue = ((st == S_DOT) || (st == S_UPD)) && (cnt < rk);

  assign ln_v[0]   = rd_v && (st == S_UPD);
  assign ln_x[0]   = $signed(i_rdata);
  assign ln_y[0]   = $signed(u_rdata);
  assign ln_k[0]   = rd_k;
  assign ln_reg[0] = ureg;
  assign ln_v[1]   = d_v[0];
  assign ln_x[1]   = d_new[0];
  assign ln_y[1]   = d_x;
  assign ln_k[1]   = d_k[0];
  assign ln_reg[1] = ireg;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      grad[l]   = (54'(a_p1[l]) <<< 5) - (54'(a_p2[l]) <<< 1);
      grad_r[l] = grad[l] + 54'sd32768;
      prod[l]   = (56'(c_h[l]) <<< 16) + $signed({24'b0, c_l[l]});
      prod_r[l] = prod[l] + 56'sd32768;
      dsum[l]   = 42'(c_y[l]) + $signed(prod_r[l][55:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= '0;
      b_v <= '0;
      c_v <= '0;
      d_v <= '0;
    end else begin
      a_v <= ln_v;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
    for (int l = 0; l < 2; l++) begin
      a_p1[l]  <= err * ln_x[l];
      a_p2[l]  <= $signed({1'b0, ln_reg[l]}) * ln_y[l];
      a_y[l]   <= ln_y[l];
      a_k[l]   <= ln_k[l];
      b_g[l]   <= grad_r[l][53:16];
      b_y[l]   <= a_y[l];
      b_k[l]   <= a_k[l];
      c_h[l]   <= $signed({1'b0, lr}) * $signed(b_g[l][37:16]);
      c_l[l]   <= lr * b_g[l][15:0];
      c_y[l]   <= b_y[l];
      c_k[l]   <= b_k[l];
      d_new[l] <= rlmf_pkg::sat_q(64'(dsum[l]));
      d_k[l]   <= c_k[l];
    end
    a_x <= ln_x[0];
    b_x <= a_x;
    c_x <= b_x;
    d_x <= c_x;
  end

  // factor memories
  always_comb begin
    u_we    = (accept && (in_op == rlmf_pkg::OP_WR_USER) && u_ok && p_ok) || d_v[0];
    u_waddr = d_v[0] ? ubase + UAW'(d_k[0]) : u_row_base + UAW'(in_pos);
    u_wdata = d_v[0] ? d_new[0] : in_val;
    u_raddr = (st == S_IDLE) ? u_row_base + UAW'(in_pos) : ubase + UAW'(cnt);
    i_we    = (accept && (in_op == rlmf_pkg::OP_WR_ITEM) && i_ok && p_ok) || d_v[1];
    i_waddr = d_v[1] ? ibase + IAW'(d_k[1]) : i_row_base + IAW'(in_pos);
    i_wdata = d_v[1] ? d_new[1] : in_val;
    i_raddr = (st == S_IDLE) ? i_row_base + IAW'(in_pos) : ibase + IAW'(cnt);
  end

  always_comb begin
    ur_we    = ((st == S_CLEAR) && (int'(clr) < NUM_USERS)) ||
               (accept && (in_op == rlmf_pkg::OP_SET_URANK) && u_ok);
    ur_waddr = (st == S_CLEAR) ? URW'(clr) : URW'(in_user);
    ur_wdata = (st == S_CLEAR) ? RKW'(1) : rclamp;
    ir_we    = ((st == S_CLEAR) && (int'(clr) < NUM_ITEMS)) ||
               (accept && (in_op == rlmf_pkg::OP_SET_IRANK) && i_ok);
    ir_waddr = (st == S_CLEAR) ? IRW'(clr) : IRW'(in_item);
    ir_wdata = (st == S_CLEAR) ? RKW'(1) : rclamp;
  end

  rlmf_ram #(.WIDTH(VW), .DEPTH(NUM_USERS * FAC_DIM)) u_user_fac (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  rlmf_ram #(.WIDTH(VW), .DEPTH(NUM_ITEMS * FAC_DIM)) u_item_fac (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  rlmf_ram #(.WIDTH(RKW), .DEPTH(NUM_USERS)) u_user_rank (
    .clk(clk), .we(ur_we), .waddr(ur_waddr), .wdata(ur_wdata),
    .raddr(URW'(in_user)), .rdata(ur_rdata)
  );

  rlmf_ram #(.WIDTH(RKW), .DEPTH(NUM_ITEMS)) u_item_rank (
    .clk(clk), .we(ir_we), .waddr(ir_waddr), .wdata(ir_wdata),
    .raddr(IRW'(in_item)), .rdata(ir_rdata)
  );

  // dot product
  assign acc_r = acc + ACC_W'(2048);
  assign acc_s = acc_r >>> 12;
  assign diff  = (VW+1)'(val_q) - (VW+1)'(est);

  always_ff @(posedge clk) begin
    pp <= $signed(u_rdata) * $signed(i_rdata);
    rd_k <= cnt;
    if (rst) begin
      rd_v <= 1'b0;
      pv   <= 1'b0;
    end else begin
      rd_v <= issue;
      pv   <= rd_v && (st == S_DOT);
    end
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lr   <= rlmf_pkg::COEF_RESET;
      ureg <= rlmf_pkg::COEF_RESET;
      ireg <= rlmf_pkg::COEF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rlmf_pkg::CFG_LEARN_RATE: lr   <= cfg_data;
        rlmf_pkg::CFG_USER_REG:   ureg <= cfg_data;
        rlmf_pkg::CFG_ITEM_REG:   ireg <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (issue) begin
      cnt <= cnt + RKW'(1);
    end
    if (pv) begin
      acc <= acc + ACC_W'(pp);
    end
    if (rst) begin
      st       <= S_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (st != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_CLEAR: begin
          clr <= clr + CLW'(1);
          if (int'(clr) == CLR_N - 1) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q     <= in_op;
            val_q    <= in_val;
            ubase    <= u_row_base;
            ibase    <= i_row_base;
            res_val  <= '0;
            res_rank <= '0;
            unique case (in_op)
              rlmf_pkg::OP_RD_USER: begin
                if (u_ok && p_ok) begin
                  st <= S_FRD;
                end else begin
                  st <= S_DONE;
                end
              end
              rlmf_pkg::OP_RD_ITEM: begin
                if (i_ok && p_ok) begin
                  st <= S_FRD;
                end else begin
                  st <= S_DONE;
                end
              end
              rlmf_pkg::OP_ESTIMATE,
              rlmf_pkg::OP_TRAIN: begin
                if (u_ok && i_ok) begin
                  st <= S_RANK;
                end else begin
                  st <= S_DONE;
                end
              end
              default: st <= S_DONE;
            endcase
          end
        end
        S_FRD: begin
          res_val <= (op_q == rlmf_pkg::OP_RD_USER) ? $signed(u_rdata) : $signed(i_rdata);
          st      <= S_DONE;
        end
        S_RANK: begin
          rk  <= (ur_rdata < ir_rdata) ? ur_rdata : ir_rdata;
          cnt <= '0;
          acc <= '0;
          st  <= S_DOT;
        end
        S_DOT: begin
          if (!issue && !rd_v && !pv) begin
            st <= S_EST;
          end
        end
        S_EST: begin
          est <= rlmf_pkg::sat_q(64'(acc_s));
          if (op_q == rlmf_pkg::OP_ESTIMATE) begin
            res_val  <= rlmf_pkg::sat_q(64'(acc_s));
            res_rank <= rk;
            st       <= S_DONE;
          end else begin
            st <= S_ERR;
          end
        end
        S_ERR: begin
          err <= rlmf_pkg::sat_q(64'(diff));
          cnt <= '0;
          st  <= S_UPD;
        end
        S_UPD: begin
          if (!issue && !rd_v && (a_v == '0) && (b_v == '0) && (c_v == '0) &&
              (d_v == '0)) begin
            res_val  <= err;
            res_rank <= rk;
            st       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(rlmf_pkg::OUT_DATA_W - VW - rlmf_pkg::RANK_OUT_W)'(0),
                         rlmf_pkg::RANK_OUT_W'(res_rank), res_val};
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `RLMF_ASSERT_IMPLIES(a_rank_range, clk, rst, st == S_DOT, (rk != '0) && (int'(rk) <= FAC_DIM), "active rank out of range")
  `RLMF_ASSERT_IMPLIES(a_cnt_bound, clk, rst, (st == S_DOT) || (st == S_UPD), cnt <= rk, "factor counter beyond rank")
  `RLMF_ASSERT_IMPLIES(a_lanes_in_upd, clk, rst, (a_v != '0) || (b_v != '0) || (c_v != '0) || (d_v != '0), st == S_UPD, "update lane active outside update pass")
  `RLMF_ASSERT_NEXT(a_result_load, clk, rst, (st == S_DONE) && (!m_tvalid || m_tready), m_tvalid && (st == S_IDLE), "result not loaded")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: factorization update engine testbench
// Drives factor loads, rank sets, estimates, trains and reads over the
// stream port. A local model of both factor tables and the row ranks
// predicts results not fixed by dir_tab. Random gaps on both sides, one
// long output stall. Several coefficient settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

  localparam int NROW = 1024;
  localparam int NPOS = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [rlmf_pkg::VALUE_W-1:0]    value;
    logic [rlmf_pkg::RANK_OUT_W-1:0] rank;
  } result_t;

  typedef struct {
    rlmf_pkg::op_t op;
    int            user;
    int            item;
    int            pos;
    logic [23:0]   value;
    bit            typed;
    logic [23:0]   exp_value;
    int            exp_rank;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rlmf_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [rlmf_pkg::OP_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rlmf_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rlmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rlmf_pkg::COEF_W-1:0] cfg_data = '0;

  rank_limited_mf_sgd_update dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [23:0] user_fac [NROW][NPOS];
  logic signed [23:0] item_fac [NROW][NPOS];
  bit user_known [NROW][NPOS];
  bit item_known [NROW][NPOS];
  int user_rank [NROW];
  int item_rank [NROW];
  longint learn_rate, user_wt, item_wt;

  result_t pending_results [$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  dir_row_t dir_tab [20] = '{
    '{rlmf_pkg::OP_WR_USER,   0,    0,    0,  24'h7FFFFF, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_WR_ITEM,   0,    0,    0,  24'h800000, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_RD_USER,   0,    0,    0,  24'h000000, 1, 24'h7FFFFF, 0},
    '{rlmf_pkg::OP_RD_ITEM,   0,    0,    0,  24'h000000, 1, 24'h800000, 0},
    '{rlmf_pkg::OP_ESTIMATE,  0,    0,    0,  24'h000000, 1, 24'h800000, 1},
    '{rlmf_pkg::OP_TRAIN,     0,    0,    0,  24'h7FFFFF, 0, 24'h000000, 0},
    '{rlmf_pkg::OP_SET_URANK, 1023, 0,    0,  24'hFFFFFB, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_SET_IRANK, 0,    1023, 0,  24'h7FFFFF, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_SET_URANK, 1,    0,    0,  24'h000000, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_SET_IRANK, 0,    1,    0,  24'h000028, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_WR_USER,   1023, 0,    31, 24'h001000, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_RD_USER,   1023, 0,    31, 24'h000000, 1, 24'h001000, 0},
    '{rlmf_pkg::OP_WR_USER,   1023, 0,    0,  24'h001000, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_WR_ITEM,   0,    1023, 0,  24'h002000, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_ESTIMATE,  1023, 1023, 0,  24'h000000, 1, 24'h002000, 1},
    '{rlmf_pkg::OP_TRAIN,     1023, 1023, 0,  24'h000000, 0, 24'h000000, 0},
    '{rlmf_pkg::OP_RD_USER,   1023, 0,    0,  24'h000000, 0, 24'h000000, 0},
    '{rlmf_pkg::OP_RD_ITEM,   0,    1023, 0,  24'h000000, 0, 24'h000000, 0},
    '{rlmf_pkg::OP_WR_ITEM,   0,    1023, 31, 24'hFFFFFF, 1, 24'h000000, 0},
    '{rlmf_pkg::OP_RD_ITEM,   0,    1023, 31, 24'h000000, 1, 24'hFFFFFF, 0}
  };

  function automatic longint round_q(longint x, int s);
    longint y;
    y = x + (longint'(1) << (s - 1));
    return y >>> s;
  endfunction

  function automatic longint sat_val(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic longint step_fac(longint y, longint x, longint e, longint wt);
    longint grad, g12;
    grad = 2 * ((e * x) * 16 - wt * y);
    g12 = round_q(grad, 16);
    return sat_val(y + round_q(learn_rate * g12, 16));
  endfunction

  function automatic int eff_rank(int u, int it);
    return (user_rank[u] < item_rank[it]) ? user_rank[u] : item_rank[it];
  endfunction

  function automatic result_t predict_result(rlmf_pkg::op_t op, int u, int it, int p,
                                             logic [23:0] v);
    result_t r;
    longint val, acc, est, err;
    int rk;
    val = longint'($signed(v));
    r = '0;
    case (op)
      rlmf_pkg::OP_WR_USER: begin
        user_fac[u][p] = v;
        user_known[u][p] = 1'b1;
      end
      rlmf_pkg::OP_WR_ITEM: begin
        item_fac[it][p] = v;
        item_known[it][p] = 1'b1;
      end
      rlmf_pkg::OP_SET_URANK:
        user_rank[u] = (val < 1) ? 1 : (val > NPOS) ? NPOS : int'(val);
      rlmf_pkg::OP_SET_IRANK:
        item_rank[it] = (val < 1) ? 1 : (val > NPOS) ? NPOS : int'(val);
      rlmf_pkg::OP_ESTIMATE, rlmf_pkg::OP_TRAIN: begin
        rk = eff_rank(u, it);
        acc = 0;
        for (int k = 0; k < rk; k++)
          acc += longint'(user_fac[u][k]) * longint'(item_fac[it][k]);
        est = sat_val(round_q(acc, 12));
        r.rank = rlmf_pkg::RANK_OUT_W'(rk);
        if (op == rlmf_pkg::OP_ESTIMATE) begin
          r.value = 24'(est);
        end else begin
          err = sat_val(val - est);
          for (int k = 0; k < rk; k++)
            user_fac[u][k] = 24'(step_fac(user_fac[u][k], item_fac[it][k], err, user_wt));
          for (int k = 0; k < rk; k++)
            item_fac[it][k] = 24'(step_fac(item_fac[it][k], user_fac[u][k], err, item_wt));
          r.value = 24'(err);
        end
      end
      rlmf_pkg::OP_RD_USER: r.value = user_fac[u][p];
      default: r.value = item_fac[it][p];
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic take_gap();
    if (idle_on && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_item(rlmf_pkg::op_t op, int u, int it, int p, logic [23:0] v,
                           bit typed = 0, logic [23:0] tv = '0, int trk = 0);
    result_t r;
    take_gap();
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, v, 5'(p), 10'(it), 10'(u)};
    do @(posedge clk); while (!s_tready);
    r = predict_result(op, u, it, p, v);
    if (typed) begin
      r.value = tv;
      r.rank = rlmf_pkg::RANK_OUT_W'(trk);
    end
    pending_results = {pending_results, r};
  endtask

  task automatic write_coefs(logic [15:0] lr, logic [15:0] uw, logic [15:0] iw);
    logic [15:0] vals [3];
    vals = '{lr, uw, iw};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= rlmf_pkg::cfg_idx_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    learn_rate = lr;
    user_wt = uw;
    item_wt = iw;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic int pick_row();
    int pool [8] = '{0, 1, 2, 3, 1020, 1021, 1022, 1023};
    if ($urandom_range(99) < 12) return $urandom_range(NROW - 1);
    return pool[$urandom_range(7)];
  endfunction

  function automatic logic [23:0] pick_value(int spread);
    if ($urandom_range(99) < 25) return 24'($urandom);
    return 24'($urandom_range(2 * spread) - spread);
  endfunction

  task automatic random_item();
    int sel, u, it, p, rk;
    rlmf_pkg::op_t op;
    logic [23:0] v;
    sel = $urandom_range(99);
    u = pick_row();
    it = pick_row();
    p = $urandom_range(NPOS - 1);
    if (sel < 35) op = rlmf_pkg::OP_TRAIN;
    else if (sel < 53) op = rlmf_pkg::OP_ESTIMATE;
    else if (sel < 61) op = rlmf_pkg::OP_WR_USER;
    else if (sel < 69) op = rlmf_pkg::OP_WR_ITEM;
    else if (sel < 74) op = rlmf_pkg::OP_SET_URANK;
    else if (sel < 79) op = rlmf_pkg::OP_SET_IRANK;
    else if (sel < 90) op = rlmf_pkg::OP_RD_USER;
    else op = rlmf_pkg::OP_RD_ITEM;
    case (op)
      rlmf_pkg::OP_TRAIN, rlmf_pkg::OP_ESTIMATE: begin
        rk = eff_rank(u, it);
        for (int k = 0; k < rk; k++) begin
          if (!user_known[u][k])
            send_item(rlmf_pkg::OP_WR_USER, u, it, k, pick_value(8192));
          if (!item_known[it][k])
            send_item(rlmf_pkg::OP_WR_ITEM, u, it, k, pick_value(8192));
        end
        v = pick_value(20480);
      end
      rlmf_pkg::OP_SET_URANK, rlmf_pkg::OP_SET_IRANK:
        v = ($urandom_range(99) < 20) ? 24'($urandom) : 24'($urandom_range(43) - 3);
      rlmf_pkg::OP_RD_USER: begin
        if (!user_known[u][p]) send_item(rlmf_pkg::OP_WR_USER, u, it, p, pick_value(8192));
        v = 24'($urandom);
      end
      rlmf_pkg::OP_RD_ITEM: begin
        if (!item_known[it][p]) send_item(rlmf_pkg::OP_WR_ITEM, u, it, p, pick_value(8192));
        v = 24'($urandom);
      end
      default: v = pick_value(8192);
    endcase
    send_item(op, u, it, p, v);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", m_tdata, '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[23:0] !== want.value) report("result_value", m_tdata[23:0], want.value);
          if (m_tdata[29:24] !== want.rank) report("rank_used", m_tdata[29:24], want.rank);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_on || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] coef_set [5][3];
    coef_set = '{'{16'd0, 16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
                 '{16'd655, 16'd300, 16'd1000}, '{16'd3000, 16'd0, 16'hFFFF},
                 '{16'd0, 16'd0, 16'd0}};
    for (int r = 0; r < NROW; r++) begin
      user_rank[r] = 1;
      item_rank[r] = 1;
    end
    learn_rate = 655;
    user_wt = 655;
    item_wt = 655;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].user, dir_tab[i].item, dir_tab[i].pos,
                dir_tab[i].value, dir_tab[i].typed, dir_tab[i].exp_value,
                dir_tab[i].exp_rank);
    s_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4)
        write_coefs(16'($urandom), 16'($urandom), 16'($urandom));
      else
        write_coefs(coef_set[ph][0], coef_set[ph][1], coef_set[ph][2]);
      idle_on = (ph != 1);
      for (int n = 0; n < 130; n++) begin
        if (ph == 2 && n == 40) hold_req = 1'b1;
        random_item();
      end
      s_tvalid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
